/* hdl/xrand_pkg.sv */
// ============================================================================
// xrand_pkg
// Shared types and constants for the xoshiro256** random unit: request
// codes, generator reset words, splitmix64 constants and sequencer states.
// ============================================================================
package xrand_pkg;

    // Request kinds
    localparam logic [1:0] FUNC_RAW  = 2'd0;
    localparam logic [1:0] FUNC_FRAC = 2'd1;
    localparam logic [1:0] FUNC_INT  = 2'd2;
    localparam logic [1:0] FUNC_FLAG = 2'd3;

    localparam int WORD_W   = 64;
    localparam int FRAC_W   = 53;
    localparam int PROB_W   = 54;
    localparam int NUM_GEN  = 4;

    // Generator words after reset
    localparam logic [63:0] GEN_INIT [NUM_GEN] = '{
        64'h6c62272e07bb0142,
        64'h62b821756295c58d,
        64'h51503d7f8c6f5a34,
        64'h92ba0b2f7823feab
    };

    // splitmix64 constants
    localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;

    // xoshiro256** shift and rotate amounts
    localparam int XS_SHIFT = 17;
    localparam int XS_ROT   = 45;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_ADD,
        ST_SEED_MUL,
        ST_START,
        ST_DRAW_MUL5,
        ST_DRAW_MUL9,
        ST_POST,
        ST_DIV,
        ST_ADD_LO,
        ST_DONE
    } t_state;

endpackage

/* hdl/xrand_if.sv */
// ============================================================================
// xrand_if
// Valid/ready channels of the random unit: the request channel and the
// response channel, each with a source and a sink view.
// ============================================================================

// Request channel
interface xrand_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [63:0] range_low;
    logic signed [63:0] range_high;
    logic [53:0]        probability;

    modport source (output valid, output func, output range_low,
                    output range_high, output probability, input ready);
    modport sink   (input valid, input func, input range_low,
                    input range_high, input probability, output ready);
endinterface

// Response channel
interface xrand_rsp_if;
    logic               valid;
    logic               ready;
    logic [63:0]        raw_word;
    logic [52:0]        unit_fraction;
    logic signed [63:0] int_value;
    logic               flag;

    modport source (output valid, output raw_word, output unit_fraction,
                    output int_value, output flag, input ready);
    modport sink   (input valid, input raw_word, input unit_fraction,
                    input int_value, input flag, output ready);
endinterface

/* hdl/xoshiro256ss_random_unit.sv */
// ============================================================================
// xoshiro256ss_random_unit
// xoshiro256** generator with splitmix64 reseeding; returns a raw word, a
// 53-bit unit fraction, a bounded integer or a Bernoulli flag per request.
// ============================================================================
//
// Usage:
//   i_req takes one request word (kind, range bounds, probability); o_rsp
//   returns one response word per request. Both use valid/ready.
//   The unit handles one request at a time; i_req.ready is high only while
//   the sequencer is idle.
// Sequence (accept to o_rsp.valid):
//   raw word, fraction, flag, full-range integer: start, draw, post, done.
//   empty or single range integer: start, then done.
//   bounded integer: start, draw, post, divide, low-bound add, done, with a
//   radix-2 restoring divider: one quotient bit per cycle, 65-bit subtractor.
// Seeding: a write on i_cfg_we starts four splitmix64 rounds on one shared
//   32x32 multiplier (three partial products per 64-bit product); requests
//   are held off until the last round is done.
// Reset: generator words return to their fixed start values, no seeding.
// Stall: a finished response sits in the output register; the next request
//   is taken meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module xoshiro256ss_random_unit
    import xrand_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    xrand_req_if.sink   i_req,
    xrand_rsp_if.source o_rsp
);

    t_state r_state, n_state;

    logic [63:0] r_w [NUM_GEN];
    logic [63:0] n_w [NUM_GEN];

    // seeding datapath
    logic [63:0] r_z, n_z;
    logic [63:0] r_mop, n_mop;
    logic [63:0] r_acc, n_acc;
    logic [1:0]  r_mstep, n_mstep;
    logic        r_msel, n_msel;
    logic [1:0]  r_round, n_round;

    // request word
    logic [1:0]         r_func, n_func;
    logic signed [63:0] r_lo, n_lo;
    logic signed [63:0] r_hi, n_hi;
    logic [53:0]        r_prob, n_prob;

    // draw and divide datapath
    logic [63:0] r_span, n_span;
    logic [63:0] r_t, n_t;
    logic [63:0] r_raw, n_raw;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_dvd, n_dvd;
    logic [5:0]  r_count, n_count;
    logic [63:0] r_ival, n_ival;
    logic        r_flag, n_flag;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_o_raw, n_o_raw;
    logic [52:0] r_o_frac, n_o_frac;
    logic [63:0] r_o_ival, n_o_ival;
    logic        r_o_flag, n_o_flag;

    logic        req_fire;
    logic        empty_range;
    logic        span_zero;
    logic        out_free;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] mul_k;
    logic [63:0] z_sum;
    logic [63:0] rot7;
    logic [64:0] div_shift, div_trial;
    logic [63:0] d_sh, d_w2, d_w3, d_w1, d_w0;

    assign i_req.ready = (r_state == ST_IDLE) && !i_cfg_we;
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;
    assign empty_range = (r_lo >= r_hi);
    assign span_zero   = (r_span == '0);

    // shared multiplier: one 32x32 partial product per step
    assign mul_k = r_msel ? SM_MUL2 : SM_MUL1;
    always_comb begin
        case (r_mstep)
            2'd0:    begin mul_a = r_mop[31:0];  mul_b = mul_k[31:0];  end
            2'd1:    begin mul_a = r_mop[31:0];  mul_b = mul_k[63:32]; end
            2'd2:    begin mul_a = r_mop[63:32]; mul_b = mul_k[31:0];  end
            default: begin mul_a = '0;           mul_b = '0;           end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign z_sum = r_z + SM_GOLDEN;
    assign rot7  = {r_t[56:0], r_t[63:57]};

    // one restoring division step
    assign div_shift = {r_rem, r_dvd[63]};
    assign div_trial = div_shift - {1'b0, r_span};

    // xoshiro256** state transition
    assign d_sh = r_w[1] << XS_SHIFT;
    assign d_w2 = r_w[2] ^ r_w[0];
    assign d_w3 = r_w[3] ^ r_w[1];
    assign d_w1 = r_w[1] ^ d_w2;
    assign d_w0 = r_w[0] ^ d_w3;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cfg_we) begin
                    n_state = ST_SEED_ADD;
                end else if (req_fire) begin
                    n_state = ST_START;
                end
            end
            ST_SEED_ADD: n_state = ST_SEED_MUL;
            ST_SEED_MUL: begin
                if (r_mstep == 2'd3 && r_msel) begin
                    n_state = (r_round == 2'(NUM_GEN - 1)) ? ST_IDLE : ST_SEED_ADD;
                end
            end
            ST_START: begin
                if (r_func == FUNC_INT && empty_range) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DRAW_MUL5;
                end
            end
            ST_DRAW_MUL5: n_state = ST_DRAW_MUL9;
            ST_DRAW_MUL9: n_state = ST_POST;
            ST_POST: begin
                if (r_func == FUNC_INT && !span_zero) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (r_count == '0) begin
                    n_state = ST_ADD_LO;
                end
            end
            ST_ADD_LO: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        for (int i = 0; i < NUM_GEN; i++) begin
            n_w[i] = r_w[i];
        end
        n_z      = r_z;
        n_mop    = r_mop;
        n_acc    = r_acc;
        n_mstep  = r_mstep;
        n_msel   = r_msel;
        n_round  = r_round;
        n_func   = r_func;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_prob   = r_prob;
        n_span   = r_span;
        n_t      = r_t;
        n_raw    = r_raw;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_count  = r_count;
        n_ival   = r_ival;
        n_flag   = r_flag;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_o_raw  = r_o_raw;
        n_o_frac = r_o_frac;
        n_o_ival = r_o_ival;
        n_o_flag = r_o_flag;

        case (r_state)
            ST_IDLE: begin
                if (i_cfg_we) begin
                    n_z     = i_cfg_wdata;
                    n_round = '0;
                end else if (req_fire) begin
                    n_func = i_req.func;
                    n_lo   = i_req.range_low;
                    n_hi   = i_req.range_high;
                    n_prob = i_req.probability;
                end
            end
            // z += golden, then first mix of the round
            ST_SEED_ADD: begin
                n_z     = z_sum;
                n_mop   = z_sum ^ (z_sum >> 30);
                n_msel  = 1'b0;
                n_mstep = '0;
            end
            // low 64 bits of mop * constant, from three partial products
            ST_SEED_MUL: begin
                n_mstep = r_mstep + 2'd1;
                case (r_mstep)
                    2'd0: n_acc = mul_p;
                    2'd1, 2'd2: n_acc = {r_acc[63:32] + mul_p[31:0], r_acc[31:0]};
                    default: begin
                        if (!r_msel) begin
                            n_mop  = r_acc ^ (r_acc >> 27);
                            n_msel = 1'b1;
                        end else begin
                            n_z          = r_acc;
                            n_w[r_round] = r_acc ^ (r_acc >> 31);
                            n_round      = r_round + 2'd1;
                        end
                    end
                endcase
            end
            ST_START: begin
                n_raw  = '0;
                n_ival = '0;
                n_flag = 1'b0;
                n_span = r_hi - r_lo + 64'd1;
                if (r_func == FUNC_INT && empty_range) begin
                    n_ival = r_lo;
                end
            end
            // w1 * 5 and the generator step
            ST_DRAW_MUL5: begin
                n_t    = r_w[1] + (r_w[1] << 2);
                n_w[0] = d_w0;
                n_w[1] = d_w1;
                n_w[2] = d_w2 ^ d_sh;
                n_w[3] = {d_w3[63-XS_ROT:0], d_w3[63:64-XS_ROT]};
            end
            // rotl(., 7) * 9
            ST_DRAW_MUL9: begin
                n_raw = rot7 + (rot7 << 3);
            end
            // probability above one compares true against any fraction anyway
            ST_POST: begin
                n_dvd   = r_raw;
                n_rem   = '0;
                n_count = 6'd63;
                if (r_func == FUNC_FLAG) begin
                    n_flag = ({1'b0, r_raw[63:64-FRAC_W]} < r_prob);
                end
                if (r_func == FUNC_INT && span_zero) begin
                    n_ival = r_lo + r_raw;
                end
            end
            ST_DIV: begin
                n_dvd   = r_dvd << 1;
                n_count = r_count - 6'd1;
                n_rem   = div_trial[64] ? div_shift[63:0] : div_trial[63:0];
            end
            ST_ADD_LO: begin
                n_ival = r_lo + r_rem;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_o_raw  = r_raw;
                    n_o_frac = r_raw[63:64-FRAC_W];
                    n_o_ival = r_ival;
                    n_o_flag = r_flag;
                end
            end
            default: ;
        endcase
    end

    // control and generator registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_GEN; i++) begin
                r_w[i] <= GEN_INIT[i];
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            for (int i = 0; i < NUM_GEN; i++) begin
                r_w[i] <= n_w[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_z      <= n_z;
        r_mop    <= n_mop;
        r_acc    <= n_acc;
        r_mstep  <= n_mstep;
        r_msel   <= n_msel;
        r_round  <= n_round;
        r_func   <= n_func;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_prob   <= n_prob;
        r_span   <= n_span;
        r_t      <= n_t;
        r_raw    <= n_raw;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_count  <= n_count;
        r_ival   <= n_ival;
        r_flag   <= n_flag;
        r_o_raw  <= n_o_raw;
        r_o_frac <= n_o_frac;
        r_o_ival <= n_o_ival;
        r_o_flag <= n_o_flag;
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.raw_word      = r_o_raw;
    assign o_rsp.unit_fraction = r_o_frac;
    assign o_rsp.int_value     = r_o_ival;
    assign o_rsp.flag          = r_o_flag;

endmodule

/* hdl/xrand_checker.sv */
// ============================================================================
// xrand_checker
// Port-level checks on the random unit, attached to the unit by bind.
// ============================================================================
module xrand_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [63:0] i_rsp_raw,
    input logic [63:0] i_rsp_ival
);

    // response word holds while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_raw) && $stable(i_rsp_ival))
        else $error("response dropped or changed while stalled");

    // nothing pending right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // one request at a time: busy after an accept
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // a seed write holds off requests while the words reload
    a_busy_after_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_req_ready)
        else $error("request path open during seeding");

endmodule

bind xoshiro256ss_random_unit xrand_checker u_xrand_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_raw   (o_rsp.raw_word),
    .i_rsp_ival  (o_rsp.int_value)
);

/* verif/xoshiro256ss_random_unit_tb.sv */
// ============================================================================
// xoshiro256ss_random_unit_tb
// Self-checking bench for the xoshiro256** random unit. It keeps its own
// copy of the four generator words and the splitmix64 reload, and predicts
// every response word at the moment its request is accepted. Directed
// corner requests come first: reset words, seed extremes, range and
// probability edges. A long random mix across several reseeds follows, with
// bursty requests and a response side that stalls on its own pattern.
// ============================================================================
module xoshiro256ss_random_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xrand_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int SEED_SETTLE   = 8;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int RANDOM_PHASES = 6;

    // xoshiro256** scrambler: rotl(s1 * 5, 7) * 9
    localparam logic [63:0] SCR_MUL_A = 64'd5;
    localparam logic [63:0] SCR_MUL_B = 64'd9;
    localparam int          SCR_ROT   = 7;

    localparam logic signed [63:0] INT_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] INT_MAX  = 64'sh7fff_ffff_ffff_ffff;
    localparam logic [PROB_W-1:0]  PROB_ONE = 54'd1 << FRAC_W;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [63:0] range_low;
        logic signed [63:0] range_high;
        logic [PROB_W-1:0]  probability;
    } t_rand_request;

    typedef struct packed {
        logic [63:0]        raw_word;
        logic [FRAC_W-1:0]  unit_fraction;
        logic signed [63:0] int_value;
        logic               flag;
    } t_rand_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [63:0] i_cfg_wdata;

    xrand_req_if req_if ();
    xrand_rsp_if rsp_if ();

    xoshiro256ss_random_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Predictor state and bookkeeping
    logic [63:0]  gen_state [NUM_GEN];
    t_rand_result pending_results [$];
    t_rand_result arrived_word;
    t_rand_result wanted_word;
    int           fail_count;
    int           burst_left;
    int           idle_cycles;
    int           kind_count [4];
    int           empty_range_count;
    int           full_range_count;
    int           flag_true_count;
    int           seeds_loaded;
    int           results_checked;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // One xoshiro256** step on the predictor's words
    function automatic logic [63:0] advance_generator();
        logic [63:0] word;
        logic [63:0] shifted;
        word    = rotl64(gen_state[1] * SCR_MUL_A, SCR_ROT) * SCR_MUL_B;
        shifted = gen_state[1] << XS_SHIFT;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= shifted;
        gen_state[3] = rotl64(gen_state[3], XS_ROT);
        return word;
    endfunction

    // Four chained splitmix64 rounds fill the generator words
    function automatic void reload_from_seed(input logic [63:0] seed);
        logic [63:0] z;
        z = seed;
        for (int i = 0; i < NUM_GEN; i++) begin
            z = z + SM_GOLDEN;
            z = (z ^ (z >> 30)) * SM_MUL1;
            z = (z ^ (z >> 27)) * SM_MUL2;
            gen_state[i] = z ^ (z >> 31);
        end
    endfunction

    function automatic t_rand_result predict_rand_result(input t_rand_request rq);
        t_rand_result      r;
        logic [63:0]       ulo;
        logic [63:0]       uhi;
        logic [63:0]       span;
        logic [63:0]       word;
        logic [PROB_W-1:0] p;
        r   = '0;
        ulo = rq.range_low;
        uhi = rq.range_high;
        if (rq.func == FUNC_INT) begin
            // empty or single range: no draw, result is the low bound
            if (rq.range_low >= rq.range_high) begin
                r.int_value = rq.range_low;
            end else begin
                word            = advance_generator();
                r.raw_word      = word;
                r.unit_fraction = word[63 -: FRAC_W];
                span            = uhi - ulo + 64'd1;
                r.int_value     = (span == 64'd0) ? ulo + word : ulo + (word % span);
            end
        end else begin
            word            = advance_generator();
            r.raw_word      = word;
            r.unit_fraction = word[63 -: FRAC_W];
            if (rq.func == FUNC_FLAG) begin
                // probability saturates at one
                p      = (rq.probability > PROB_ONE) ? PROB_ONE : rq.probability;
                r.flag = ({1'b0, r.unit_fraction} < p);
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Drive one request word, wait for it to be taken, record its prediction
    task automatic send_request(input logic [1:0] kind, input logic signed [63:0] lo,
                                input logic signed [63:0] hi,
                                input logic [PROB_W-1:0] prob);
        t_rand_request rq;
        t_rand_result  res;
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        rq.func        = kind;
        rq.range_low   = lo;
        rq.range_high  = hi;
        rq.probability = prob;
        req_if.valid       <= 1'b1;
        req_if.func        <= kind;
        req_if.range_low   <= lo;
        req_if.range_high  <= hi;
        req_if.probability <= prob;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        res = predict_rand_result(rq);
        pending_results.push_back(res);
        kind_count[kind]++;
        if (kind == FUNC_INT && lo >= hi) empty_range_count++;
        if (kind == FUNC_INT && lo == INT_MIN && hi == INT_MAX) full_range_count++;
        if (res.flag) flag_true_count++;
    endtask

    // Hold requests until every response is back
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Seed write only with the unit idle
    task automatic write_seed(input logic [63:0] seed);
        drain_responses();
        repeat (SEED_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reload_from_seed(seed);
        seeds_loaded++;
    endtask

    // Draws straight from the reset words, before any seeding
    task automatic test_reset_words();
        send_request(FUNC_RAW, INT_MAX, INT_MIN, '1);
        send_request(FUNC_FRAC, 64'sd0, 64'sd0, '0);
        send_request(FUNC_FLAG, INT_MIN, INT_MAX, '0);
        send_request(FUNC_FLAG, 64'sd1, -64'sd1, PROB_ONE);
    endtask

    task automatic test_probability_edges();
        send_request(FUNC_FLAG, 64'sd0, 64'sd0, 54'd1);
        send_request(FUNC_FLAG, 64'sd0, 64'sd0, PROB_ONE >> 1);
        send_request(FUNC_FLAG, 64'sd0, 64'sd0, PROB_ONE - 54'd1);
        send_request(FUNC_FLAG, 64'sd0, 64'sd0, PROB_ONE + 54'd1);
        send_request(FUNC_FLAG, 64'sd0, 64'sd0, '1);
    endtask

    task automatic test_bounded_ranges();
        send_request(FUNC_INT, 64'sd5, 64'sd5, '0);        // single value
        send_request(FUNC_INT, INT_MAX, INT_MIN, '0);      // reversed bounds
        send_request(FUNC_INT, INT_MAX, INT_MAX, '1);
        send_request(FUNC_INT, INT_MIN, INT_MAX, '0);      // span wraps to zero
        send_request(FUNC_INT, INT_MIN, INT_MAX - 64'sd1, '0);
        send_request(FUNC_INT, 64'sd0, INT_MAX, '0);
        send_request(FUNC_INT, -64'sd1, 64'sd0, '0);       // span of two
        send_request(FUNC_INT, -64'sd10, 64'sd10, '0);
    endtask

    // Reload from the seed extremes, one draw after each
    task automatic test_seed_extremes();
        write_seed(64'h0000_0000_0000_0000);
        send_request(FUNC_RAW, 64'sd0, 64'sd0, '0);
        write_seed(64'hffff_ffff_ffff_ffff);
        send_request(FUNC_FRAC, 64'sd0, 64'sd0, '0);
        write_seed(64'h8000_0000_0000_0000);
        send_request(FUNC_INT, INT_MIN, 64'sd0, '0);
        write_seed(64'h7fff_ffff_ffff_ffff);
        send_request(FUNC_FLAG, 64'sd0, 64'sd0, PROB_ONE >> 2);
    endtask

    // Random mix of all request kinds, reseeded between phases
    task automatic test_random_traffic();
        logic [1:0]         kind;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic signed [63:0] tmp;
        logic [PROB_W-1:0]  prob;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph != 0) write_seed(rand64());
            repeat (RANDOM_ITEMS / RANDOM_PHASES) begin
                kind = 2'($urandom_range(0, 3));
                lo   = rand64();
                hi   = rand64();
                case ($urandom_range(0, 3))
                    0: begin
                        prob = PROB_W'(rand64());
                    end
                    3: begin
                        prob = ($urandom_range(0, 1) == 1) ? PROB_ONE
                                                           : PROB_W'($urandom_range(0, 15));
                    end
                    default: begin
                        prob = PROB_W'(rand64()) % (PROB_ONE + 54'd1);
                    end
                endcase
                // mostly ranges that draw, a share of empty and full ones
                if (kind == FUNC_INT) begin
                    case ($urandom_range(0, 9))
                        0: begin
                            if (lo < hi) begin
                                tmp = lo;
                                lo  = hi;
                                hi  = tmp;
                            end
                        end
                        1: begin
                            lo = INT_MIN;
                            hi = INT_MAX;
                        end
                        2: ;
                        3, 4, 5: begin
                            hi = lo + 64'($urandom_range(1, 1000));
                        end
                        6: begin
                            hi = lo + 64'($urandom());
                        end
                        default: begin
                            if (lo > hi) begin
                                tmp = lo;
                                lo  = hi;
                                hi  = tmp;
                            end
                        end
                    endcase
                end
                send_request(kind, lo, hi, prob);
            end
        end
    endtask

    // Response check against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            arrived_word.raw_word      = rsp_if.raw_word;
            arrived_word.unit_fraction = rsp_if.unit_fraction;
            arrived_word.int_value     = rsp_if.int_value;
            arrived_word.flag          = rsp_if.flag;
            if (pending_results.size() == 0) begin
                $error("response word with none outstanding: raw_word %h",
                       arrived_word.raw_word);
                fail_count++;
            end else begin
                wanted_word = pending_results.pop_front();
                results_checked++;
                if (arrived_word.raw_word !== wanted_word.raw_word) begin
                    $error("raw_word: expected %h, got %h",
                           wanted_word.raw_word, arrived_word.raw_word);
                    fail_count++;
                end
                if (arrived_word.unit_fraction !== wanted_word.unit_fraction) begin
                    $error("unit_fraction: expected %h, got %h",
                           wanted_word.unit_fraction, arrived_word.unit_fraction);
                    fail_count++;
                end
                if (arrived_word.int_value !== wanted_word.int_value) begin
                    $error("int_value: expected %0d, got %0d",
                           wanted_word.int_value, arrived_word.int_value);
                    fail_count++;
                end
                if (arrived_word.flag !== wanted_word.flag) begin
                    $error("flag: expected %b, got %b",
                           wanted_word.flag, arrived_word.flag);
                    fail_count++;
                end
            end
        end
    end

    // Response-side stalls: free-running, random, or a rotating mask
    initial begin
        int          hold;
        int          mode;
        logic [7:0]  mask;
        hold = 0;
        mode = 0;
        mask = '1;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                mode = $urandom_range(0, 2);
                hold = $urandom_range(20, 200);
                mask = 8'($urandom_range(1, 255));
            end
            hold--;
            case (mode)
                0: begin
                    rsp_if.ready <= 1'b1;
                end
                1: begin
                    rsp_if.ready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    rsp_if.ready <= mask[0];
                    mask = {mask[0], mask[7:1]};
                end
            endcase
        end
    end

    // Watchdog: cycles without any handshake or seed write
    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) || i_cfg_we === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $error("no progress for %0d cycles, %0d responses outstanding",
               IDLE_LIMIT, pending_results.size());
        $display("FAIL");
        $finish;
    end

    // Test sequence
    initial begin
        fail_count        = 0;
        burst_left        = 0;
        idle_cycles       = 0;
        empty_range_count = 0;
        full_range_count  = 0;
        flag_true_count   = 0;
        seeds_loaded      = 0;
        results_checked   = 0;
        for (int k = 0; k < 4; k++) kind_count[k] = 0;
        for (int i = 0; i < NUM_GEN; i++) gen_state[i] = GEN_INIT[i];

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        req_if.valid       <= 1'b0;
        req_if.func        <= FUNC_RAW;
        req_if.range_low   <= '0;
        req_if.range_high  <= '0;
        req_if.probability <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_words();
        test_probability_edges();
        test_bounded_ranges();
        test_seed_extremes();
        test_random_traffic();

        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d responses never arrived", pending_results.size());
            fail_count++;
        end

        $display("Checked %0d responses: %0d raw, %0d fraction, %0d bounded, %0d flag requests.",
                 results_checked, kind_count[FUNC_RAW], kind_count[FUNC_FRAC],
                 kind_count[FUNC_INT], kind_count[FUNC_FLAG]);
        $display("Ranges: %0d empty, %0d full; %0d flags set; %0d seed reloads; %0d errors.",
                 empty_range_count, full_range_count, flag_true_count, seeds_loaded,
                 fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
